@@ rtl/csu_pkg.sv @@
package csu_pkg;

	localparam int DEF_MAX_LEN   = 1024;
	localparam int DEF_ELEM_BITS = 16;

	// Result format: signed Q1.15
	localparam int COS_W     = 16;
	localparam int FRAC_BITS = 15;
	// Quotient bits kept by the divider; larger quotients are flagged as overflow
	localparam int QUO_W     = FRAC_BITS + 2;
	localparam int CNT_W     = $clog2(QUO_W);

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MUL_AB,
		ST_MUL_AA,
		ST_MUL_BB,
		ST_ACC,
		ST_CHECK,
		ST_SQRT_A,
		ST_SQRT_B_INIT,
		ST_SQRT_B,
		ST_DEN,
		ST_DIV_INIT,
		ST_DIV,
		ST_EMIT
	} state_t;

	typedef enum logic [1:0] {
		MUL_AB,
		MUL_AA,
		MUL_BB
	} mul_sel_t;

	typedef enum logic [1:0] {
		ACC_NONE,
		ACC_DOT,
		ACC_SQA,
		ACC_SQB
	} acc_sel_t;

	typedef struct packed {
		logic     ld_in;
		mul_sel_t mul_sel;
		acc_sel_t acc_sel;
		logic     clr_acc;
		logic     sq_start_a;
		logic     sq_start_b;
		logic     sq_step;
		logic     save_ra;
		logic     den_ld;
		logic     div_init;
		logic     div_step;
		logic     out_ld;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic zero;
		logic sq_fin;
		logic div_fin;
	} sts_t;

endpackage

@@ rtl/csu_dp.sv @@
module csu_dp #(
	parameter int ELEM_BITS = 16,
	parameter int MAX_LEN   = 1024
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  csu_pkg::cmd_t                        cmd,
	output csu_pkg::sts_t                        sts,
	input  logic signed [ELEM_BITS-1:0]          in_a,
	input  logic signed [ELEM_BITS-1:0]          in_b,
	input  logic                                 in_last,
	output logic        [csu_pkg::COS_W-1:0]     cos,
	output logic                                 zero_norm
);
	import csu_pkg::*;

	localparam int PROD_W = 2 * ELEM_BITS;
	localparam int DOT_W  = PROD_W + $clog2(MAX_LEN);
	localparam int SQ_W   = DOT_W - 1;
	localparam int RT_W   = (SQ_W + 1) / 2;
	localparam int DEN_W  = 2 * RT_W;
	localparam int REM_W  = DEN_W + 1;
	localparam int CMP_W  = DEN_W + 2;

	localparam logic [SQ_W-1:0]  SQ_TOP    = SQ_W'(1) << (2 * (RT_W - 1));
	localparam logic [QUO_W-1:0] Q_ONE     = QUO_W'(1) << FRAC_BITS;
	localparam logic [QUO_W-1:0] Q_MAX_POS = Q_ONE - QUO_W'(1);

	// input item and MAC
	logic signed [ELEM_BITS-1:0] a_q, b_q;
	logic                        last_q;
	logic signed [ELEM_BITS-1:0] op_x, op_y;
	logic signed [PROD_W-1:0]    prod, prod_q;
	logic        [DOT_W-1:0]     dot_q;
	logic        [SQ_W-1:0]      sqa_q, sqb_q;

	// shared square root unit
	logic [SQ_W-1:0] num_q, res_q, bit_q;
	logic [SQ_W:0]   trial;
	logic            take;
	logic [RT_W-1:0] ra_q;

	// divider
	logic [DEN_W-1:0] den_q;
	logic [DOT_W-1:0] mag_q;
	logic             neg_q;
	logic             ovf_q;
	logic [REM_W-1:0] rem_q, rem_sh;
	logic             ge;
	logic [QUO_W-1:0] low_q, quo_q;
	logic [CNT_W-1:0] cnt_q;

	logic [QUO_W-1:0] qs_neg, q_neg, q_pos;
	logic [COS_W-1:0] cos_q;
	logic             zn_q;
	logic             zero;

	always_comb begin
		unique case (cmd.mul_sel)
			MUL_AB: begin
				op_x = a_q;
				op_y = b_q;
			end
			MUL_AA: begin
				op_x = a_q;
				op_y = a_q;
			end
			MUL_BB: begin
				op_x = b_q;
				op_y = b_q;
			end
			default: begin
				op_x = a_q;
				op_y = b_q;
			end
		endcase
	end

	assign prod = PROD_W'(op_x) * PROD_W'(op_y);

	always_ff @(posedge clk) begin
		if (cmd.ld_in) begin
			a_q <= in_a;
			b_q <= in_b;
		end
		prod_q <= prod;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
			dot_q  <= '0;
			sqa_q  <= '0;
			sqb_q  <= '0;
		end else begin
			if (cmd.ld_in)
				last_q <= in_last;
			if (cmd.clr_acc) begin
				dot_q <= '0;
				sqa_q <= '0;
				sqb_q <= '0;
			end else begin
				unique case (cmd.acc_sel)
					ACC_NONE: ;
					ACC_DOT:  dot_q <= dot_q + DOT_W'(prod_q);
					ACC_SQA:  sqa_q <= sqa_q + SQ_W'(prod_q);
					ACC_SQB:  sqb_q <= sqb_q + SQ_W'(prod_q);
					default:  ;
				endcase
			end
		end
	end

	assign zero = (sqa_q == '0) || (sqb_q == '0);

	// digit-by-digit root, one result bit per step
	assign trial = {1'b0, res_q} + {1'b0, bit_q};
	assign take  = {1'b0, num_q} >= trial;

	always_ff @(posedge clk) begin
		if (cmd.sq_start_a || cmd.sq_start_b) begin
			num_q <= cmd.sq_start_b ? sqb_q : sqa_q;
			res_q <= '0;
			bit_q <= SQ_TOP;
		end else if (cmd.sq_step) begin
			if (take) begin
				num_q <= num_q - trial[SQ_W-1:0];
				res_q <= (res_q >> 1) + bit_q;
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
		if (cmd.save_ra)
			ra_q <= res_q[RT_W-1:0];
	end

	// restoring division of |dot| * 2^15 by root_a * root_b
	assign rem_sh = {rem_q[REM_W-2:0], low_q[QUO_W-1]};
	assign ge     = rem_sh >= REM_W'(den_q);

	always_ff @(posedge clk) begin
		if (cmd.den_ld) begin
			den_q <= DEN_W'(ra_q) * DEN_W'(res_q[RT_W-1:0]);
			neg_q <= dot_q[DOT_W-1];
			mag_q <= dot_q[DOT_W-1] ? (~dot_q + DOT_W'(1)) : dot_q;
		end
		if (cmd.div_init) begin
			ovf_q <= CMP_W'(mag_q) >= {den_q, 2'b00};
			rem_q <= REM_W'(mag_q >> 2);
			low_q <= {mag_q[1:0], FRAC_BITS'(0)};
			quo_q <= '0;
			cnt_q <= CNT_W'(QUO_W - 1);
		end else if (cmd.div_step) begin
			rem_q <= ge ? (rem_sh - REM_W'(den_q)) : rem_sh;
			quo_q <= {quo_q[QUO_W-2:0], ge};
			low_q <= low_q << 1;
			cnt_q <= cnt_q - CNT_W'(1);
		end
	end

	// saturate to Q1.15
	always_comb begin
		qs_neg = (ovf_q || (quo_q > Q_ONE)) ? Q_ONE : quo_q;
		q_neg  = ~qs_neg + QUO_W'(1);
		q_pos  = (ovf_q || (quo_q > Q_MAX_POS)) ? Q_MAX_POS : quo_q;
	end

	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			zn_q <= zero;
			if (zero)
				cos_q <= '0;
			else if (neg_q)
				cos_q <= q_neg[COS_W-1:0];
			else
				cos_q <= q_pos[COS_W-1:0];
		end
	end

	assign cos       = cos_q;
	assign zero_norm = zn_q;

	assign sts.last    = last_q;
	assign sts.zero    = zero;
	assign sts.sq_fin  = bit_q[0];
	assign sts.div_fin = (cnt_q == '0);

endmodule

@@ rtl/csu_ctrl.sv @@
module csu_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	output csu_pkg::cmd_t cmd,
	input  csu_pkg::sts_t sts
);
	import csu_pkg::*;

	state_t state_q, state_nxt;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.out_ld)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.ld_in = 1'b1;
					state_nxt = ST_MUL_AB;
				end
			end
			ST_MUL_AB: begin
				cmd.mul_sel = MUL_AB;
				state_nxt   = ST_MUL_AA;
			end
			ST_MUL_AA: begin
				cmd.mul_sel = MUL_AA;
				cmd.acc_sel = ACC_DOT;
				state_nxt   = ST_MUL_BB;
			end
			ST_MUL_BB: begin
				cmd.mul_sel = MUL_BB;
				cmd.acc_sel = ACC_SQA;
				state_nxt   = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_sel = ACC_SQB;
				if (sts.last) begin
					state_nxt = ST_CHECK;
				end else begin
					s_tready = 1'b1;
					if (s_tvalid) begin
						cmd.ld_in = 1'b1;
						state_nxt = ST_MUL_AB;
					end else begin
						state_nxt = ST_IDLE;
					end
				end
			end
			ST_CHECK: begin
				if (sts.zero) begin
					state_nxt = ST_EMIT;
				end else begin
					cmd.sq_start_a = 1'b1;
					state_nxt      = ST_SQRT_A;
				end
			end
			ST_SQRT_A: begin
				cmd.sq_step = 1'b1;
				if (sts.sq_fin)
					state_nxt = ST_SQRT_B_INIT;
			end
			ST_SQRT_B_INIT: begin
				cmd.save_ra    = 1'b1;
				cmd.sq_start_b = 1'b1;
				state_nxt      = ST_SQRT_B;
			end
			ST_SQRT_B: begin
				cmd.sq_step = 1'b1;
				if (sts.sq_fin)
					state_nxt = ST_DEN;
			end
			ST_DEN: begin
				cmd.den_ld = 1'b1;
				state_nxt  = ST_DIV_INIT;
			end
			ST_DIV_INIT: begin
				cmd.div_init = 1'b1;
				state_nxt    = ST_DIV;
			end
			ST_DIV: begin
				cmd.div_step = 1'b1;
				if (sts.div_fin)
					state_nxt = ST_EMIT;
			end
			ST_EMIT: begin
				if (!out_valid_q || m_tready) begin
					cmd.out_ld  = 1'b1;
					cmd.clr_acc = 1'b1;
					state_nxt   = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	assign m_tvalid = out_valid_q;

endmodule

@@ rtl/cosine_similarity_unit_core.sv @@
// channel | dir | tdata (low bit up)                 | tlast      | tuser
// s_*     | in  | elem_a, elem_b (zero padded)       | last pair  | -
// m_*     | out | cosine (signed Q1.15)              | -          | zero_norm
//
// Items: one shared multiplier forms a*b, a*a, b*b of an item without last in turn,
// then its last sum is accumulated while the next item can already be taken.
// An item with last then runs two serial roots on one shared unit, one bit per
// cycle, then a 17-step restoring divider; with a zero norm it skips both and
// goes from the zero check straight to the output register.
// Reset: arst_n clears the controller, output valid and the accumulators.
// Stalls: the result sits in an output register; new items are taken while it
// waits, and only the next result waits for m_tready.
module cosine_similarity_unit_core #(
	parameter int MAX_LEN   = csu_pkg::DEF_MAX_LEN,
	parameter int ELEM_BITS = csu_pkg::DEF_ELEM_BITS
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	// slave side: item = one element pair
	input  logic                                 s_tvalid,
	output logic                                 s_tready,
	input  logic [((2*ELEM_BITS+7)/8)*8-1:0]     s_tdata,  // elem_a, elem_b, pad
	input  logic                                 s_tlast,  // last
	// master side: one item per vector pair
	output logic                                 m_tvalid,
	input  logic                                 m_tready,
	output logic [csu_pkg::COS_W-1:0]            m_tdata,  // cosine
	output logic                                 m_tuser   // zero_norm
);
	import csu_pkg::*;

	cmd_t cmd;
	sts_t sts;

	logic signed [ELEM_BITS-1:0] elem_a, elem_b;

	// tdata unpack; pad bits above the two elements are ignored
	assign elem_a = s_tdata[ELEM_BITS-1:0];
	assign elem_b = s_tdata[2*ELEM_BITS-1:ELEM_BITS];

	// sequencer: MAC steps per item, then root/root/multiply/divide on last unless a norm is zero
	csu_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.cmd      (cmd),
		.sts      (sts)
	);

	// accumulators, shared root unit, divider, output register
	csu_dp #(
		.ELEM_BITS (ELEM_BITS),
		.MAX_LEN   (MAX_LEN)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_a      (elem_a),
		.in_b      (elem_b),
		.in_last   (s_tlast),
		.cos       (m_tdata),
		.zero_norm (m_tuser)
	);

	// each item needs several cycles of MAC work before the next one
	a_no_back_to_back: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("item taken in consecutive cycles");

	// a last item runs at least the zero-check path before input reopens
	a_last_holds_off: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready && s_tlast |=> !s_tready ##1 !s_tready ##1 !s_tready)
		else $error("input reopened too early after last");

	// zero norm forces a zero cosine
	a_zero_norm_cos: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser |-> m_tdata == '0)
		else $error("zero_norm with nonzero cosine");

endmodule
